### hw/rtl/bpp_pkg.sv
// shared types, constants and fixed-point helpers for the boris particle pusher
package bpp_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = WORD_W / 2;
    localparam int PROD_W = 2 * WORD_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word ONE_FX   = t_word'(1) <<< FRAC_W;

    // configuration register indexes
    localparam logic [2:0] CFG_CHARGE  = 3'd0;
    localparam logic [2:0] CFG_MASS    = 3'd1;
    localparam logic [2:0] CFG_STEP    = 3'd2;
    localparam logic [2:0] CFG_FIELD_X = 3'd3;
    localparam logic [2:0] CFG_FIELD_Y = 3'd4;
    localparam logic [2:0] CFG_FIELD_Z = 3'd5;

    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word vel_x;
        t_word vel_y;
        t_word vel_z;
    } t_particle;

    typedef struct packed {
        t_word new_pos_x;
        t_word new_pos_y;
        t_word new_pos_z;
        t_word new_vel_x;
        t_word new_vel_y;
        t_word new_vel_z;
    } t_result;

    // per-configuration coefficients handed to the datapath
    typedef struct packed {
        t_word tx;
        t_word ty;
        t_word tz;
        t_word sx;
        t_word sy;
        t_word sz;
        t_word dt;
    } t_coef;

    // round an exact product to nearest, ties away from zero, then saturate
    function automatic t_word fx_rnd(input t_prod p);
        logic                neg;
        logic [PROD_W-1:0]   mg;
        logic [PROD_W-1:0]   r;
        t_word               res;
        neg = p[PROD_W-1];
        mg  = neg ? PROD_W'(-p) : PROD_W'(p);
        r   = (mg + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        if (neg) begin
            if (r > (PROD_W'(1) << (WORD_W - 1))) res = WORD_MIN;
            else res = t_word'(-r[WORD_W-1:0]);
        end else begin
            if (r > PROD_W'(WORD_MAX)) res = WORD_MAX;
            else res = t_word'(r[WORD_W-1:0]);
        end
        return res;
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        t_word                  res;
        s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
        if (s > (WORD_W+1)'(WORD_MAX)) res = WORD_MAX;
        else if (s < (WORD_W+1)'(WORD_MIN)) res = WORD_MIN;
        else res = s[WORD_W-1:0];
        return res;
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        t_word                  res;
        s = (WORD_W+1)'(a) - (WORD_W+1)'(b);
        if (s > (WORD_W+1)'(WORD_MAX)) res = WORD_MAX;
        else if (s < (WORD_W+1)'(WORD_MIN)) res = WORD_MIN;
        else res = s[WORD_W-1:0];
        return res;
    endfunction

endpackage

### hw/rtl/bpp_div.sv
// iterative restoring divider for fixed-point quotients, one bit per cycle
module bpp_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  bpp_pkg::t_word       i_num,
    input  logic [bpp_pkg::WORD_W-1:0] i_den,
    output logic                 o_done,
    output bpp_pkg::t_word       o_quo
);
    import bpp_pkg::*;

    localparam int DVD_W = WORD_W + FRAC_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [WORD_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_dq;
    logic [WORD_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_fin;
    logic              r_neg;
    logic              r_done;
    t_word             r_quo;

    logic [WORD_W:0]   trial;
    logic              ge;
    logic [WORD_W-1:0] n_rem;
    logic [WORD_W-1:0] num_mag;
    logic              rnd_up;
    logic [DVD_W:0]    q_rnd;
    t_word             q_sat;

    // magnitude of the numerator
    assign num_mag = i_num[WORD_W-1] ? WORD_W'(-i_num) : WORD_W'(i_num);

    // one restoring step
    always_comb begin
        trial = {r_rem, r_dq[DVD_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? WORD_W'(trial - {1'b0, r_den}) : trial[WORD_W-1:0];
    end

    // round half away and saturate
    always_comb begin
        rnd_up = {1'b0, r_rem} >= ({1'b0, r_den} - {1'b0, r_rem});
        q_rnd  = {1'b0, r_dq} + (DVD_W+1)'(rnd_up);
        if (r_neg) begin
            if (q_rnd > (DVD_W+1)'(1) << (WORD_W - 1)) q_sat = WORD_MIN;
            else q_sat = t_word'(-q_rnd[WORD_W-1:0]);
        end else begin
            if (q_rnd > (DVD_W+1)'(WORD_MAX)) q_sat = WORD_MAX;
            else q_sat = t_word'(q_rnd[WORD_W-1:0]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_go) begin
                r_run <= (i_den != '0);
                r_done <= (i_den == '0);
                r_cnt <= CNT_W'(DVD_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_dq  <= {num_mag, {FRAC_W{1'b0}}};
            r_den <= i_den;
            r_neg <= i_num[WORD_W-1];
            if (i_num[WORD_W-1]) r_quo <= WORD_MIN;
            else if (i_num != '0) r_quo <= WORD_MAX;
            else r_quo <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[DVD_W-2:0], ge};
        end else if (r_fin) begin
            r_quo <= q_sat;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/bpp_coef.sv
// configuration registers and the sequencer that derives t and s from them
module bpp_coef (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [bpp_pkg::WORD_W-1:0] i_cfg_data,
    output logic                 o_busy,
    output bpp_pkg::t_coef       o_coef
);
    import bpp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_RND  = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    localparam logic [3:0] STEP_QHD  = 4'd0;
    localparam logic [3:0] STEP_C    = 4'd1;
    localparam logic [3:0] STEP_TX   = 4'd2;
    localparam logic [3:0] STEP_TY   = 4'd3;
    localparam logic [3:0] STEP_TZ   = 4'd4;
    localparam logic [3:0] STEP_SQX  = 4'd5;
    localparam logic [3:0] STEP_SQY  = 4'd6;
    localparam logic [3:0] STEP_SQZ  = 4'd7;
    localparam logic [3:0] STEP_SX   = 4'd8;
    localparam logic [3:0] STEP_SY   = 4'd9;
    localparam logic [3:0] STEP_SZ   = 4'd10;

    t_word             r_charge, r_fx, r_fy, r_fz;
    logic [WORD_W-2:0] r_mass, r_dt;

    t_state      r_state;
    logic [3:0]  r_step;
    logic        r_div_go;
    t_prod       r_prod;
    t_word       r_cnum, r_c, r_acc, r_den;
    t_word       r_tx, r_ty, r_tz, r_sx, r_sy, r_sz;

    t_word       hd;
    t_word       mul_a, mul_b;
    t_word       div_num;
    logic [WORD_W-1:0] div_den;
    t_word       rnd;
    logic        div_done;
    t_word       div_quo;
    logic [3:0]  step_nx;

    assign hd      = t_word'(({1'b0, r_dt} + WORD_W'(1)) >> 1);
    assign rnd     = fx_rnd(r_prod);
    assign step_nx = r_step + 4'd1;

    // operand selection per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        unique case (r_step)
            STEP_QHD: begin mul_a = r_charge; mul_b = hd; end
            STEP_C: begin div_num = r_cnum; div_den = {1'b0, r_mass}; end
            STEP_TX: begin mul_a = r_c; mul_b = r_fx; end
            STEP_TY: begin mul_a = r_c; mul_b = r_fy; end
            STEP_TZ: begin mul_a = r_c; mul_b = r_fz; end
            STEP_SQX: begin mul_a = r_tx; mul_b = r_tx; end
            STEP_SQY: begin mul_a = r_ty; mul_b = r_ty; end
            STEP_SQZ: begin mul_a = r_tz; mul_b = r_tz; end
            STEP_SX: begin div_num = sat_add(r_tx, r_tx); div_den = r_den; end
            STEP_SY: begin div_num = sat_add(r_ty, r_ty); div_den = r_den; end
            STEP_SZ: begin div_num = sat_add(r_tz, r_tz); div_den = r_den; end
            default: begin end
        endcase
    end

    bpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge <= -ONE_FX;
            r_mass   <= (WORD_W-1)'(ONE_FX);
            r_dt     <= (WORD_W-1)'((ONE_FX + 5) / 10);
            r_fx     <= '0;
            r_fy     <= '0;
            r_fz     <= ONE_FX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHARGE:  r_charge <= i_cfg_data;
                CFG_MASS:    r_mass   <= i_cfg_data[WORD_W-2:0];
                CFG_STEP:    r_dt     <= i_cfg_data[WORD_W-2:0];
                CFG_FIELD_X: r_fx     <= i_cfg_data;
                CFG_FIELD_Y: r_fy     <= i_cfg_data;
                CFG_FIELD_Z: r_fz     <= i_cfg_data;
                default: begin end
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_MUL;
            r_step   <= STEP_QHD;
            r_div_go <= 1'b0;
        end else if (i_cfg_we) begin
            r_state  <= ST_MUL;
            r_step   <= STEP_QHD;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin end
                ST_MUL: r_state <= ST_RND;
                ST_RND: begin
                    r_step <= step_nx;
                    if (step_nx == STEP_C || step_nx == STEP_SX) begin
                        r_state  <= ST_DIV;
                        r_div_go <= 1'b1;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (div_done && !r_div_go) begin
                        if (r_step == STEP_SZ) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_step <= step_nx;
                            if (r_step == STEP_C) begin
                                r_state <= ST_MUL;
                            end else begin
                                r_div_go <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) r_prod <= mul_a * mul_b;
        if (r_state == ST_RND) begin
            unique case (r_step)
                STEP_QHD: r_cnum <= rnd;
                STEP_TX:  r_tx   <= rnd;
                STEP_TY:  r_ty   <= rnd;
                STEP_TZ:  r_tz   <= rnd;
                STEP_SQX: r_acc  <= rnd;
                STEP_SQY: r_acc  <= sat_add(r_acc, rnd);
                STEP_SQZ: r_den  <= sat_add(ONE_FX, sat_add(r_acc, rnd));
                default: begin end
            endcase
        end
        if (r_state == ST_DIV && div_done && !r_div_go) begin
            unique case (r_step)
                STEP_C:  r_c  <= div_quo;
                STEP_SX: r_sx <= div_quo;
                STEP_SY: r_sy <= div_quo;
                STEP_SZ: r_sz <= div_quo;
                default: begin end
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_coef.tx = r_tx;
        o_coef.ty = r_ty;
        o_coef.tz = r_tz;
        o_coef.sx = r_sx;
        o_coef.sy = r_sy;
        o_coef.sz = r_sz;
        o_coef.dt = t_word'({1'b0, r_dt});
    end

endmodule

### hw/rtl/bpp_pipe.sv
// eight-stage rotation and position update datapath, one particle per cycle
module bpp_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  bpp_pkg::t_particle   i_particle,
    input  bpp_pkg::t_coef       i_coef,
    output logic                 o_vld,
    output bpp_pkg::t_result     o_result
);
    import bpp_pkg::*;

    localparam int DEPTH = 8;

    logic [DEPTH-1:0] r_vld;

    t_word r1_p [3], r1_v [3];
    t_prod r1_m [6];
    t_word r2_p [3], r2_v [3], r2_r [6];
    t_word r3_p [3], r3_v [3], r3_w [3];
    t_word r4_p [3], r4_v [3];
    t_prod r4_m [6];
    t_word r5_p [3], r5_v [3], r5_r [6];
    t_word r6_p [3], r6_n [3];
    t_word r7_p [3], r7_n [3];
    t_prod r7_m [3];
    t_result r_out;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[DEPTH-2:0], i_vld};
    end

    always_ff @(posedge i_clk) begin
        // stage 1: v x t products
        r1_p[0] <= i_particle.pos_x;
        r1_p[1] <= i_particle.pos_y;
        r1_p[2] <= i_particle.pos_z;
        r1_v[0] <= i_particle.vel_x;
        r1_v[1] <= i_particle.vel_y;
        r1_v[2] <= i_particle.vel_z;
        r1_m[0] <= i_particle.vel_y * i_coef.tz;
        r1_m[1] <= i_particle.vel_z * i_coef.ty;
        r1_m[2] <= i_particle.vel_z * i_coef.tx;
        r1_m[3] <= i_particle.vel_x * i_coef.tz;
        r1_m[4] <= i_particle.vel_x * i_coef.ty;
        r1_m[5] <= i_particle.vel_y * i_coef.tx;

        // stage 2: round products
        r2_p <= r1_p;
        r2_v <= r1_v;
        for (int i = 0; i < 6; i++) r2_r[i] <= fx_rnd(r1_m[i]);

        // stage 3: v' = v + v x t
        r3_p <= r2_p;
        r3_v <= r2_v;
        for (int i = 0; i < 3; i++)
            r3_w[i] <= sat_add(r2_v[i], sat_sub(r2_r[2*i], r2_r[2*i+1]));

        // stage 4: v' x s products
        r4_p <= r3_p;
        r4_v <= r3_v;
        r4_m[0] <= r3_w[1] * i_coef.sz;
        r4_m[1] <= r3_w[2] * i_coef.sy;
        r4_m[2] <= r3_w[2] * i_coef.sx;
        r4_m[3] <= r3_w[0] * i_coef.sz;
        r4_m[4] <= r3_w[0] * i_coef.sy;
        r4_m[5] <= r3_w[1] * i_coef.sx;

        // stage 5: round products
        r5_p <= r4_p;
        r5_v <= r4_v;
        for (int i = 0; i < 6; i++) r5_r[i] <= fx_rnd(r4_m[i]);

        // stage 6: new velocity
        r6_p <= r5_p;
        for (int i = 0; i < 3; i++)
            r6_n[i] <= sat_add(r5_v[i], sat_sub(r5_r[2*i], r5_r[2*i+1]));

        // stage 7: displacement products
        r7_p <= r6_p;
        r7_n <= r6_n;
        for (int i = 0; i < 3; i++) r7_m[i] <= r6_n[i] * i_coef.dt;

        // stage 8: position update into the output register
        r_out.new_pos_x <= sat_add(r7_p[0], fx_rnd(r7_m[0]));
        r_out.new_pos_y <= sat_add(r7_p[1], fx_rnd(r7_m[1]));
        r_out.new_pos_z <= sat_add(r7_p[2], fx_rnd(r7_m[2]));
        r_out.new_vel_x <= r7_n[0];
        r_out.new_vel_y <= r7_n[1];
        r_out.new_vel_z <= r7_n[2];
    end

    assign o_vld    = r_vld[DEPTH-1];
    assign o_result = r_out;

endmodule

### hw/rtl/boris_particle_push.sv
// top level of the boris particle pusher
//
//  channel   signals                          direction  handshake
//  request   start, busy, i_particle          in         start && !busy
//  result    o_valid, o_result                out        o_valid, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  in         i_cfg_we
//
// one particle per cycle while busy is low; results are registered.
// t and s are derived from the registers by a shared multiplier and a
// bit-serial divider after reset and after any register write, while
// busy is high and no request is taken.
// the datapath never stalls; results are shown for a single cycle.
module boris_particle_push (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bpp_pkg::t_particle         i_particle,
    output logic                       o_valid,
    output bpp_pkg::t_result           o_result,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [bpp_pkg::WORD_W-1:0] i_cfg_data
);
    import bpp_pkg::*;

    t_coef coef;
    logic  coef_busy;
    logic  accept;

    assign busy   = coef_busy;
    assign accept = start && !coef_busy;

    // coefficient unit
    bpp_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (coef_busy),
        .o_coef     (coef)
    );

    // particle datapath
    bpp_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (accept),
        .i_particle (i_particle),
        .i_coef     (coef),
        .o_vld      (o_valid),
        .o_result   (o_result)
    );

endmodule

### hw/rtl/bpp_check.sv
// port-level checker for the boris particle pusher, bound to the top level
module bpp_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       i_cfg_we
);

    // every request gives a result on o_valid
    a_req_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_valid)
        else $error("request without result");

    // every result traces back to a request
    a_res_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 8))
        else $error("result without request");

    // a register write starts a recompute
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("no recompute after register write");

    // coefficients are recomputed after reset
    a_rst_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("not busy after reset");

endmodule

bind boris_particle_push bpp_check u_bpp_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .i_cfg_we (i_cfg_we)
);
